FILE: src/hinge_angular_velocity_unit_assert.svh
// assertion macros for the hinge angular velocity unit checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef HINGE_ANGULAR_VELOCITY_UNIT_ASSERT_SVH
`define HINGE_ANGULAR_VELOCITY_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define HAV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define HAV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hav_pkg.sv
// shared constants, codes and helper functions of the hinge angular velocity unit
// no dependencies
package hav_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;

  localparam logic [CFG_W-1:0] GAIN_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MAX_RST  = 31'd655360;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_CLAMP  = 3'd1;
  localparam logic [2:0] ST_BADCFG = 3'd2;
  localparam logic [2:0] ST_AXIS   = 3'd3;
  localparam logic [2:0] ST_RADIUS = 3'd4;

  localparam logic [63:0] AXIS_MIN_SQ   = 64'd1073741824;
  localparam logic [63:0] RADIUS_MIN_SQ = 64'd10737419;

  // widths of the square root unit
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;

  localparam logic signed [65:0] MAG_POS = 66'sd4294967295;
  localparam logic signed [65:0] MAG_NEG = -66'sd4294967295;

  // side data carried through the square root
  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] v;
    logic [2:0][31:0] a;
    logic             axis_short;
  } sq_side_t;

  // side data carried through the unit axis divider
  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] v;
    logic [2:0]       neg;
    logic             axis_short;
  } ax_side_t;

  // side data carried through the final divider
  typedef struct packed {
    logic neg;
    logic ovf;
    logic axis_short;
    logic radius_short;
  } fin_side_t;

  // point minus pivot, saturated to 32 bits
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] q,
                                                  input logic signed [31:0] p);
    logic signed [32:0] t;
    t = 33'(q) - 33'(p);
    if (t[32] != t[31]) begin
      return t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return t[31:0];
  endfunction

  // signed divide by 2^30, toward zero
  function automatic logic signed [65:0] trunc_q30(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + (x[65] ? 66'sd1073741823 : 66'sd0);
    return t >>> 30;
  endfunction

  // signed divide by 2^16, toward zero
  function automatic logic signed [65:0] trunc_q16(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + (x[65] ? 66'sd65535 : 66'sd0);
    return t >>> 16;
  endfunction

  // limit magnitude to 2^32-1
  function automatic logic signed [32:0] clamp_mag32(input logic signed [65:0] x);
    if (x > MAG_POS) begin
      return MAG_POS[32:0];
    end
    if (x < MAG_NEG) begin
      return MAG_NEG[32:0];
    end
    return x[32:0];
  endfunction

endpackage

FILE: src/hav_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on hav_pkg
module hav_sqrt import hav_pkg::*; #(
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   x_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned NS = ROOT_W;

  logic            vld_q  [NS];
  logic [SQ_W-1:0] x_q    [NS];
  logic [SQ_W-1:0] r_q    [NS];
  logic [SW-1:0]   side_q [NS];

  logic            vld_c  [NS];
  logic [SQ_W-1:0] x_c    [NS];
  logic [SQ_W-1:0] r_c    [NS];
  logic [SW-1:0]   side_c [NS];
  logic [SQ_W-1:0] x_d    [NS];
  logic [SQ_W-1:0] r_d    [NS];

  always_comb begin
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        vld_c[k]  = valid_i;
        x_c[k]    = x_i;
        r_c[k]    = '0;
        side_c[k] = side_i;
      end else begin
        vld_c[k]  = vld_q[k-1];
        x_c[k]    = x_q[k-1];
        r_c[k]    = r_q[k-1];
        side_c[k] = side_q[k-1];
      end
      b = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      t = r_c[k] + b;
      if (x_c[k] >= t) begin
        x_d[k] = x_c[k] - t;
        r_d[k] = (r_c[k] >> 1) + b;
      end else begin
        x_d[k] = x_c[k];
        r_d[k] = r_c[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= vld_c[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        x_q[k]    <= x_d[k];
        r_q[k]    <= r_d[k];
        side_q[k] <= side_c[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = r_q[NS-1][ROOT_W-1:0];
  assign side_o  = side_q[NS-1];

endmodule

FILE: src/hav_div.sv
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
// no dependencies
module hav_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned DW    = 32,
  parameter int unsigned QW    = 31,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][DW-1:0]   rem_i,
  input  logic [LANES-1:0][QW-1:0]   bits_i,
  input  logic [DW-1:0]              div_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);

  logic                     vld_q  [QW];
  logic [LANES-1:0][DW-1:0] rem_q  [QW];
  logic [LANES-1:0][QW-1:0] nq_q   [QW];
  logic [DW-1:0]            div_q  [QW];
  logic [SW-1:0]            side_q [QW];

  logic                     vld_c  [QW];
  logic [LANES-1:0][DW-1:0] rem_c  [QW];
  logic [LANES-1:0][QW-1:0] nq_c   [QW];
  logic [DW-1:0]            div_c  [QW];
  logic [SW-1:0]            side_c [QW];
  logic [LANES-1:0][DW-1:0] rem_d  [QW];
  logic [LANES-1:0][QW-1:0] nq_d   [QW];

  // nq shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        vld_c[k]  = valid_i;
        rem_c[k]  = rem_i;
        nq_c[k]   = bits_i;
        div_c[k]  = div_i;
        side_c[k] = side_i;
      end else begin
        vld_c[k]  = vld_q[k-1];
        rem_c[k]  = rem_q[k-1];
        nq_c[k]   = nq_q[k-1];
        div_c[k]  = div_q[k-1];
        side_c[k] = side_q[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_c[k][l], nq_c[k][l][QW-1]};
        diff  = trial - {1'b0, div_c[k]};
        if (trial >= {1'b0, div_c[k]}) begin
          rem_d[k][l] = diff[DW-1:0];
          nq_d[k][l]  = {nq_c[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = trial[DW-1:0];
          nq_d[k][l]  = {nq_c[k][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= vld_c[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= rem_d[k];
        nq_q[k]   <= nq_d[k];
        div_q[k]  <= div_c[k];
        side_q[k] <= side_c[k];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = nq_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

FILE: src/hinge_angular_velocity_unit.sv
// throughput: one item per cycle while the output is not stalled; the 32-stage
// square root, the 31-stage axis divider and the 47-stage quotient divider are
// fully pipelined
// a stalled output freezes the whole pipeline, bubbles included
// reset clears all valid bits and loads gain 1.0 and limit 10.0
module hinge_angular_velocity_unit import hav_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   pivot_x_i,
  input  logic signed [31:0]   pivot_y_i,
  input  logic signed [31:0]   pivot_z_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  input  logic signed [31:0]   vel_x_i,
  input  logic signed [31:0]   vel_y_i,
  input  logic signed [31:0]   vel_z_i,
  input  logic signed [31:0]   axis_x_i,
  input  logic signed [31:0]   axis_y_i,
  input  logic signed [31:0]   axis_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   angular_speed_o,
  output logic [2:0]           status_o
);

  logic en;
  logic [CFG_W-1:0] gain_q, max_q;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      max_q  <= MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN: gain_q <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  logic signed [31:0] pv [3], qv [3], vv [3], av [3];
  assign pv = '{pivot_x_i, pivot_y_i, pivot_z_i};
  assign qv = '{point_x_i, point_y_i, point_z_i};
  assign vv = '{vel_x_i, vel_y_i, vel_z_i};
  assign av = '{axis_x_i, axis_y_i, axis_z_i};

  // stage 0: axis squares and pivot-to-point difference
  logic               s0_valid_q;
  logic [63:0]        s0_asq_q [3];
  logic signed [31:0] s0_d_q [3], s0_v_q [3], s0_a_q [3];

  // sqrt input
  logic [63:0] lsq;
  sq_side_t    sq_in, sq_out;
  logic        sq_valid;
  logic [31:0] len;

  always_comb begin
    lsq = s0_asq_q[0] + s0_asq_q[1] + s0_asq_q[2];
    for (int i = 0; i < 3; i++) begin
      sq_in.d[i] = s0_d_q[i];
      sq_in.v[i] = s0_v_q[i];
      sq_in.a[i] = s0_a_q[i];
    end
    sq_in.axis_short = lsq < AXIS_MIN_SQ;
  end

  hav_sqrt #(.SW($bits(sq_side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .x_i     (lsq),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (len),
    .side_o  (sq_out)
  );

  // unit axis: |a| * 2^30 / len, 31 quotient bits
  logic [2:0][31:0] ax_rem;
  logic [2:0][30:0] ax_bits, ax_quo;
  ax_side_t         ax_in, ax_out;
  logic             ax_valid;

  always_comb begin
    logic [31:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag        = sq_out.a[i][31] ? 32'(-sq_out.a[i]) : sq_out.a[i];
      ax_rem[i]  = {1'b0, mag[31:1]};
      ax_bits[i] = {mag[0], 30'b0};
      ax_in.neg[i] = sq_out.a[i][31];
    end
    ax_in.d          = sq_out.d;
    ax_in.v          = sq_out.v;
    ax_in.axis_short = sq_out.axis_short;
  end

  hav_div #(.LANES(3), .DW(32), .QW(31), .SW($bits(ax_side_t))) u_axis_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .rem_i   (ax_rem),
    .bits_i  (ax_bits),
    .div_i   (len),
    .side_i  (ax_in),
    .valid_o (ax_valid),
    .quo_o   (ax_quo),
    .side_o  (ax_out)
  );

  // middle stages
  logic s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
  logic s7_valid_q, s8_valid_q, s9_valid_q, s10_valid_q, s11_valid_q;

  logic signed [31:0] s2_u_q [3], s2_d_q [3], s2_v_q [3];
  logic signed [63:0] s3_p_q [3];
  logic signed [31:0] s3_u_q [3], s3_d_q [3], s3_v_q [3];
  logic signed [33:0] s4_s_q;
  logic signed [31:0] s4_u_q [3], s4_d_q [3], s4_v_q [3];
  logic signed [65:0] s5_us_q [3];
  logic signed [31:0] s5_u_q [3], s5_d_q [3], s5_v_q [3];
  logic signed [32:0] s6_r_q [3];
  logic signed [31:0] s6_u_q [3], s6_v_q [3];
  logic [63:0]        s7_sq_q [3];
  logic signed [64:0] s7_wp_q [6];
  logic signed [31:0] s7_v_q [3];
  logic [63:0]        s8_rsq_q;
  logic signed [32:0] s8_w_q [3];
  logic signed [31:0] s8_v_q [3];
  logic signed [65:0] s9_wv_q [3];
  logic [63:0]        s9_rsq_q;
  logic               s9_rsh_q;
  logic signed [51:0] s10_num_q;
  logic [63:0]        s10_rsq_q;
  logic               s10_rsh_q;
  logic [50:0]        s11_n_q;
  logic [63:0]        s11_rsq_q;
  logic               s11_neg_q, s11_ovf_q, s11_rsh_q;
  logic s2_ash_q, s3_ash_q, s4_ash_q, s5_ash_q, s6_ash_q, s7_ash_q, s8_ash_q;
  logic s9_ash_q, s10_ash_q, s11_ash_q;

  logic signed [65:0] s_sum, num_sum;
  logic [65:0]        rsq_sum;
  logic [63:0]        rsq_sat;
  logic [31:0]        rmag [3];
  logic signed [65:0] wdiff [3];
  logic [50:0]        n_abs;
  logic               n_ovf;

  always_comb begin
    s_sum   = trunc_q30(66'(s3_p_q[0])) + trunc_q30(66'(s3_p_q[1]))
            + trunc_q30(66'(s3_p_q[2]));
    rsq_sum = 66'(s7_sq_q[0]) + 66'(s7_sq_q[1]) + 66'(s7_sq_q[2]);
    rsq_sat = (rsq_sum[65:64] != 2'b00) ? '1 : rsq_sum[63:0];
    for (int i = 0; i < 3; i++) begin
      rmag[i] = s6_r_q[i][32] ? 32'(-s6_r_q[i]) : s6_r_q[i][31:0];
    end
    wdiff[0] = 66'(s7_wp_q[0]) - 66'(s7_wp_q[1]);
    wdiff[1] = 66'(s7_wp_q[2]) - 66'(s7_wp_q[3]);
    wdiff[2] = 66'(s7_wp_q[4]) - 66'(s7_wp_q[5]);
    num_sum  = trunc_q16(s9_wv_q[0]) + trunc_q16(s9_wv_q[1]) + trunc_q16(s9_wv_q[2]);
    n_abs    = s10_num_q[51] ? 51'(-s10_num_q) : s10_num_q[50:0];
    // quotient of 2^15 or more clamps, unless an error status takes priority
    n_ovf    = 79'(n_abs) >= {s10_rsq_q, 15'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
      s11_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= in_valid_i;
      s2_valid_q  <= ax_valid;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
      s11_valid_q <= s10_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_asq_q[i] <= 64'(av[i] * av[i]);
        s0_d_q[i]   <= sat_diff(qv[i], pv[i]);
        s0_v_q[i]   <= vv[i];
        s0_a_q[i]   <= av[i];

        s2_u_q[i] <= ax_out.neg[i] ? -$signed({1'b0, ax_quo[i]})
                                   : $signed({1'b0, ax_quo[i]});
        s2_d_q[i] <= ax_out.d[i];
        s2_v_q[i] <= ax_out.v[i];

        s3_p_q[i] <= 64'(s2_d_q[i]) * 64'(s2_u_q[i]);
        s3_u_q[i] <= s2_u_q[i];
        s3_d_q[i] <= s2_d_q[i];
        s3_v_q[i] <= s2_v_q[i];

        s4_u_q[i] <= s3_u_q[i];
        s4_d_q[i] <= s3_d_q[i];
        s4_v_q[i] <= s3_v_q[i];

        s5_us_q[i] <= 66'(s4_u_q[i]) * 66'(s4_s_q);
        s5_u_q[i]  <= s4_u_q[i];
        s5_d_q[i]  <= s4_d_q[i];
        s5_v_q[i]  <= s4_v_q[i];

        s6_r_q[i] <= clamp_mag32(66'(s5_d_q[i]) - trunc_q30(s5_us_q[i]));
        s6_u_q[i] <= s5_u_q[i];
        s6_v_q[i] <= s5_v_q[i];

        s7_sq_q[i] <= 64'(rmag[i]) * 64'(rmag[i]);
        s7_v_q[i]  <= s6_v_q[i];

        s8_w_q[i] <= clamp_mag32(trunc_q30(wdiff[i]));
        s8_v_q[i] <= s7_v_q[i];

        s9_wv_q[i] <= 66'(s8_w_q[i]) * 66'(s8_v_q[i]);
      end
      s2_ash_q <= ax_out.axis_short;
      s3_ash_q <= s2_ash_q;
      s4_s_q   <= s_sum[33:0];
      s4_ash_q <= s3_ash_q;
      s5_ash_q <= s4_ash_q;
      s6_ash_q <= s5_ash_q;
      // u x r products
      s7_wp_q[0] <= 65'(s6_u_q[1]) * 65'(s6_r_q[2]);
      s7_wp_q[1] <= 65'(s6_u_q[2]) * 65'(s6_r_q[1]);
      s7_wp_q[2] <= 65'(s6_u_q[2]) * 65'(s6_r_q[0]);
      s7_wp_q[3] <= 65'(s6_u_q[0]) * 65'(s6_r_q[2]);
      s7_wp_q[4] <= 65'(s6_u_q[0]) * 65'(s6_r_q[1]);
      s7_wp_q[5] <= 65'(s6_u_q[1]) * 65'(s6_r_q[0]);
      s7_ash_q   <= s6_ash_q;
      s8_rsq_q   <= rsq_sat;
      s8_ash_q   <= s7_ash_q;
      s9_rsq_q   <= s8_rsq_q;
      s9_rsh_q   <= s8_rsq_q < RADIUS_MIN_SQ;
      s9_ash_q   <= s8_ash_q;
      s10_num_q  <= num_sum[51:0];
      s10_rsq_q  <= s9_rsq_q;
      s10_rsh_q  <= s9_rsh_q;
      s10_ash_q  <= s9_ash_q;
      s11_n_q    <= n_abs;
      s11_neg_q  <= s10_num_q[51];
      s11_ovf_q  <= n_ovf;
      s11_rsq_q  <= s10_rsq_q;
      s11_rsh_q  <= s10_rsh_q;
      s11_ash_q  <= s10_ash_q;
    end
  end

  // quotient n * 2^32 / |r|^2, 47 bits
  logic [0:0][63:0] fd_rem;
  logic [0:0][46:0] fd_bits, fd_quo;
  fin_side_t        fd_in, fd_out;
  logic             fd_valid;

  always_comb begin
    fd_rem[0]          = 64'(s11_n_q[50:15]);
    fd_bits[0]         = {s11_n_q[14:0], 32'b0};
    fd_in.neg          = s11_neg_q;
    fd_in.ovf          = s11_ovf_q;
    fd_in.axis_short   = s11_ash_q;
    fd_in.radius_short = s11_rsh_q;
  end

  hav_div #(.LANES(1), .DW(64), .QW(47), .SW($bits(fin_side_t))) u_quot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s11_valid_q),
    .rem_i   (fd_rem),
    .bits_i  (fd_bits),
    .div_i   (s11_rsq_q),
    .side_i  (fd_in),
    .valid_o (fd_valid),
    .quo_o   (fd_quo),
    .side_o  (fd_out)
  );

  // gain multiply, split at the binary point
  logic        s12_valid_q;
  logic [61:0] s12_m1_q;
  logic [46:0] s12_m2_q;
  fin_side_t   s12_side_q;

  logic               out_valid_q;
  logic signed [31:0] speed_q, speed_d;
  logic [2:0]         status_q, status_d;

  always_comb begin
    logic [62:0] mag;
    logic [30:0] m;
    mag      = 63'(s12_m1_q) + 63'(s12_m2_q >> 16);
    m        = '0;
    speed_d  = '0;
    status_d = ST_OK;
    if (gain_q == '0 || max_q == '0) begin
      status_d = ST_BADCFG;
    end else if (s12_side_q.axis_short) begin
      status_d = ST_AXIS;
    end else if (s12_side_q.radius_short) begin
      status_d = ST_RADIUS;
    end else begin
      if (s12_side_q.ovf || mag > 63'(max_q)) begin
        m        = max_q;
        status_d = ST_CLAMP;
      end else begin
        m = mag[30:0];
      end
      speed_d = s12_side_q.neg ? -$signed(32'(m)) : $signed(32'(m));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s12_valid_q <= fd_valid;
      out_valid_q <= s12_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s12_m1_q   <= 62'(fd_quo[0][46:16]) * 62'(gain_q);
      s12_m2_q   <= 47'(fd_quo[0][15:0]) * 47'(gain_q);
      s12_side_q <= fd_out;
      speed_q    <= speed_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign angular_speed_o = speed_q;
  assign status_o        = status_q;

endmodule

FILE: src/hav_checker.sv
// port-level checks for the hinge angular velocity unit, bound to the top level
// depends on hav_pkg and hinge_angular_velocity_unit_assert.svh
`include "hinge_angular_velocity_unit_assert.svh"

module hav_checker import hav_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] angular_speed_o,
  input logic [2:0]         status_o
);

  // result held while the output is stalled
  `HAV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(angular_speed_o) && $stable(status_o), "output item changed under stall")

  // input only stalls when a finished item is blocked
  `HAV_ASSERT_NOW(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without output backpressure")

  // error codes carry a zero result
  `HAV_ASSERT_NOW(a_err_zero,
    out_valid_o && (status_o == ST_BADCFG || status_o == ST_AXIS || status_o == ST_RADIUS),
    angular_speed_o == 32'sd0, "nonzero result with error status")

  // a clamped result sits at a nonzero limit
  `HAV_ASSERT_NOW(a_clamp_nonzero, out_valid_o && status_o == ST_CLAMP,
    angular_speed_o != 32'sd0, "clamped result is zero")

endmodule

bind hinge_angular_velocity_unit hav_checker u_hav_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .angular_speed_o (angular_speed_o),
  .status_o        (status_o)
);
